>>> src/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg: shared constants, types and fixed-point helpers
// Sample and gain widths, register indexes, sequencer control bundle and the
// Q1.15 gain product with rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package fdl_pkg;

   localparam int STORE_DEPTH = 96000;
   localparam int SAMPLE_BITS = 24;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int DELAY_BITS  = 17;
   localparam int GAIN_BITS   = 16;
   localparam int CSR_BITS    = 17;
   localparam int CSR_IDX_BITS = 2;
   localparam int DATA_BITS   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int CMP_BITS    = ((DELAY_BITS > ADDR_BITS) ? DELAY_BITS : ADDR_BITS) + 1;
   localparam int ROUND_BITS  = 15;

   localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(32768);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DELAY  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECAY  = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_WET    = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEREO = CSR_IDX_BITS'(3);

   // register reset values
   localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(24000);
   localparam logic [GAIN_BITS-1:0]  DECAY_RESET = GAIN_BITS'(9830);
   localparam logic [GAIN_BITS-1:0]  WET_RESET   = GAIN_BITS'(16384);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [PROD_BITS-1:0]   wide_type;

   // step strobes from the sequencer to the datapath
   typedef struct packed {
      logic load_in;
      logic mul1;
      logic mix;
      logic mul2;
      logic sum;
      logic stereo;
   } ctl_type;

   function automatic wide_type widen(sample_type x);
      return PROD_BITS'(x);
   endfunction

   // clamp a wide value to signed sample range
   function automatic sample_type sat(wide_type v);
      logic [PROD_BITS-SAMPLE_BITS:0] upper;
      upper = v[PROD_BITS-1:SAMPLE_BITS-1];
      if (upper == '0 || upper == '1) begin
         return v[SAMPLE_BITS-1:0];
      end else if (v[PROD_BITS-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   // floor((x * g + 2^14) / 2^15), saturated
   function automatic sample_type qmul(sample_type x, logic [GAIN_BITS-1:0] g);
      wide_type xe;
      wide_type ge;
      wide_type p;
      xe = PROD_BITS'(x);
      ge = $signed(PROD_BITS'(g));
      p  = xe * ge + $signed(PROD_BITS'(1 << (ROUND_BITS - 1)));
      return sat(p >>> ROUND_BITS);
   endfunction

endpackage

`default_nettype wire

>>> src/fdl_ram.sv
// ----------------------------------------------------------------------------
// fdl_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_ram #(
   parameter int DEPTH     = 96000,
   parameter int WIDTH     = 24,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic                 re,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> src/fdl_mix.sv
// ----------------------------------------------------------------------------
// fdl_mix: echo arithmetic datapath
// Gain products, ping-pong cross mix and saturating feedback sums, one
// registered step per sequencer strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_mix (
   input  wire logic                         clock,
   input  wire fdl_pkg::ctl_type             ctl,
   input  wire fdl_pkg::sample_type          left_in,
   input  wire fdl_pkg::sample_type          right_in,
   input  wire fdl_pkg::sample_type          left_dly,
   input  wire fdl_pkg::sample_type          right_dly,
   input  wire logic [fdl_pkg::GAIN_BITS-1:0] decay,
   input  wire logic [fdl_pkg::GAIN_BITS-1:0] wet,
   input  wire logic [fdl_pkg::GAIN_BITS-1:0] dry,
   output fdl_pkg::sample_type               left_out,
   output fdl_pkg::sample_type               right_out,
   output fdl_pkg::sample_type               left_wdata,
   output fdl_pkg::sample_type               right_wdata
);

   localparam logic signed [fdl_pkg::SAMPLE_BITS:0] ONE_W = 1;

   fdl_pkg::sample_type il_ff, ir_ff, half_ff;
   fdl_pkg::sample_type p_rw_ff, p_ld_ff, p_rdc_ff, p_ldc_ff;
   fdl_pkg::sample_type p_ild_ff, p_ird_ff, p_hw_ff;
   fdl_pkg::sample_type mixl_ff, ol_ff, a_ff, b_ff, or_ff, lst_ff;
   logic signed [fdl_pkg::SAMPLE_BITS:0] pair_sum;

   // (il + ir + 1) >> 1 equals the half-gain product and never overflows
   assign pair_sum = $signed({left_in[fdl_pkg::SAMPLE_BITS-1], left_in})
                   + $signed({right_in[fdl_pkg::SAMPLE_BITS-1], right_in}) + ONE_W;

   always_ff @(posedge clock) begin
      if (ctl.load_in) begin
         il_ff   <= left_in;
         ir_ff   <= right_in;
         half_ff <= pair_sum[fdl_pkg::SAMPLE_BITS:1];
      end
      if (ctl.mul1) begin
         p_rw_ff  <= fdl_pkg::qmul(right_dly, wet);
         p_ld_ff  <= fdl_pkg::qmul(left_dly, dry);
         p_rdc_ff <= fdl_pkg::qmul(right_dly, decay);
         p_ldc_ff <= fdl_pkg::qmul(left_dly, decay);
         p_ild_ff <= fdl_pkg::qmul(il_ff, dry);
         p_ird_ff <= fdl_pkg::qmul(ir_ff, dry);
         p_hw_ff  <= fdl_pkg::qmul(half_ff, wet);
      end
      if (ctl.mix) begin
         mixl_ff <= fdl_pkg::sat(fdl_pkg::widen(p_rw_ff) + fdl_pkg::widen(p_ld_ff));
      end
      if (ctl.mul2) begin
         // mono output is the delayed left times decay
         ol_ff <= ctl.stereo ? fdl_pkg::qmul(mixl_ff, decay) : p_ldc_ff;
         a_ff  <= fdl_pkg::qmul(p_rdc_ff, dry);
         b_ff  <= fdl_pkg::qmul(p_ldc_ff, wet);
      end
      if (ctl.sum) begin
         or_ff <= fdl_pkg::sat(fdl_pkg::widen(a_ff) + fdl_pkg::widen(b_ff));
         if (ctl.stereo) begin
            lst_ff <= fdl_pkg::sat(fdl_pkg::widen(ol_ff) + fdl_pkg::widen(p_ild_ff)
                                   + fdl_pkg::widen(p_hw_ff));
         end else begin
            lst_ff <= fdl_pkg::sat(fdl_pkg::widen(ol_ff) + fdl_pkg::widen(il_ff));
         end
      end
   end

   assign left_out    = ol_ff;
   assign right_out   = or_ff;
   assign left_wdata  = lst_ff;
   assign right_wdata = fdl_pkg::sat(fdl_pkg::widen(p_ird_ff) + fdl_pkg::widen(or_ff));

endmodule

`default_nettype wire

>>> src/feedback_delay_line_top.sv
// ----------------------------------------------------------------------------
// feedback_delay_line_top: feedback echo over a two-channel circular store
// Sequencer, delay-tap addressing, register file and result register around
// two delay memories and the echo datapath.
// ----------------------------------------------------------------------------
// Sequencing: a six-step sequencer reads both delay memories once per item
//   and writes them back in its last step (the right one only in stereo or on
//   the first lap); a new item is taken only after that step completes.
// Reset: synchronous; registers return to their defaults and the write index
//   to zero. No clearing pass: an entry not yet written since reset reads as
//   zero through the fill tracking, so items are taken the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_delay_line_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input items
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [fdl_pkg::DATA_BITS-1:0]       req_tdata,  // left_in, right_in
   input  wire logic                                req_tlast,  // end_of_block
   // result items
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [fdl_pkg::DATA_BITS-1:0]       rsp_tdata,  // left_out, right_out
   output logic                                     rsp_tlast,  // end_of_block_out
   // register writes
   input  wire logic                                csr_we,
   input  wire logic [fdl_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [fdl_pkg::CSR_BITS-1:0]        csr_wdata
);

   localparam int SB = fdl_pkg::SAMPLE_BITS;
   localparam int AB = fdl_pkg::ADDR_BITS;
   localparam int CB = fdl_pkg::CMP_BITS;
   localparam logic [AB-1:0] LAST_ADDR = AB'(fdl_pkg::STORE_DEPTH - 1);
   localparam logic [CB-1:0] MAX_DELAY = CB'(fdl_pkg::STORE_DEPTH - 1);
   localparam logic [CB-1:0] DEPTH_W   = CB'(fdl_pkg::STORE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MIX,
      ST_MUL2,
      ST_SUM,
      ST_WRITE
   } state_type;

   // ---- configuration registers ----
   logic [fdl_pkg::DELAY_BITS-1:0] delay_ff;
   logic [fdl_pkg::GAIN_BITS-1:0]  decay_ff;
   logic [fdl_pkg::GAIN_BITS-1:0]  wet_ff;
   logic                           stereo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= fdl_pkg::DELAY_RESET;
         decay_ff  <= fdl_pkg::DECAY_RESET;
         wet_ff    <= fdl_pkg::WET_RESET;
         stereo_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            fdl_pkg::CSR_DELAY:  delay_ff  <= csr_wdata[fdl_pkg::DELAY_BITS-1:0];
            fdl_pkg::CSR_DECAY:  decay_ff  <= csr_wdata[fdl_pkg::GAIN_BITS-1:0];
            fdl_pkg::CSR_WET:    wet_ff    <= csr_wdata[fdl_pkg::GAIN_BITS-1:0];
            fdl_pkg::CSR_STEREO: stereo_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // wet is capped at unity; dry is its complement
   logic [fdl_pkg::GAIN_BITS-1:0] wet_eff, dry_eff;
   assign wet_eff = (wet_ff > fdl_pkg::UNITY_GAIN) ? fdl_pkg::UNITY_GAIN : wet_ff;
   assign dry_eff = fdl_pkg::UNITY_GAIN - wet_eff;

   // ---- sequencer state and registered outputs ----
   state_type         state_ff, state_in;
   logic [AB-1:0]     w_ff, w_in;
   logic              wrapped_ff, wrapped_in;   // every entry written once
   logic              valid_ff, valid_in;       // tap entry holds written data
   logic              eob_ff, eob_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [fdl_pkg::DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic              rsp_tlast_ff, rsp_tlast_in;

   logic              req_accept;
   logic              out_free;
   logic              wr_en;
   logic [CB-1:0]     d_ext, d_clamp, w_ext, r_ext;
   logic [AB-1:0]     rd_addr;

   fdl_pkg::ctl_type    ctl;
   fdl_pkg::sample_type left_in, right_in;
   fdl_pkg::sample_type left_dly, right_dly;
   fdl_pkg::sample_type left_res, right_res, left_wdata, right_wdata;
   fdl_pkg::sample_type right_mem_wdata;
   logic [SB-1:0]       left_q, right_q;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign wr_en      = (state_ff == ST_WRITE) && out_free;

   assign left_in  = req_tdata[SB-1:0];
   assign right_in = req_tdata[2*SB-1:SB];

   // tap address: write index minus clamped delay, wrapped round the store
   always_comb begin
      d_ext = CB'(delay_ff);
      if (d_ext == '0) begin
         d_clamp = CB'(1);
      end else if (d_ext > MAX_DELAY) begin
         d_clamp = MAX_DELAY;
      end else begin
         d_clamp = d_ext;
      end
      w_ext = CB'(w_ff);
      if (w_ext >= d_clamp) begin
         r_ext = w_ext - d_clamp;
      end else begin
         r_ext = w_ext + DEPTH_W - d_clamp;
      end
      rd_addr = r_ext[AB-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      w_in          = w_ff;
      wrapped_in    = wrapped_ff;
      valid_in      = valid_ff;
      eob_in        = eob_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               valid_in = wrapped_ff || (rd_addr < w_ff);
               eob_in   = req_tlast;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1:  state_in = ST_MIX;
         ST_MIX:   state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_WRITE;
         ST_WRITE: begin
            // hold here until the result register can take the new item
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tdata_in[SB-1:0]    = left_res;
               rsp_tdata_in[2*SB-1:SB] = stereo_ff ? right_res : '0;
               rsp_tlast_in  = eob_ff;
               if (w_ff == LAST_ADDR) begin
                  w_in       = '0;
                  wrapped_in = 1'b1;
               end else begin
                  w_in = w_ff + AB'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         w_ff          <= '0;
         wrapped_ff    <= 1'b0;
         valid_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         w_ff          <= w_in;
         wrapped_ff    <= wrapped_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      eob_ff       <= eob_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // ---- delay memories: read on accept, written back in the last step ----
   fdl_ram #(
      .DEPTH (fdl_pkg::STORE_DEPTH),
      .WIDTH (SB)
   ) u_left_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (w_ff),
      .wdata (left_wdata),
      .re    (req_accept),
      .raddr (rd_addr),
      .rdata (left_q)
   );

   // mono keeps the right entry; on the first lap the entry is not yet written
   // and reads as zero through the fill tracking, so zero is written and the
   // fill tracking stays true for both stores
   assign right_mem_wdata = stereo_ff ? right_wdata : '0;

   fdl_ram #(
      .DEPTH (fdl_pkg::STORE_DEPTH),
      .WIDTH (SB)
   ) u_right_ram (
      .clock (clock),
      .we    (wr_en && (stereo_ff || !wrapped_ff)),
      .waddr (w_ff),
      .wdata (right_mem_wdata),
      .re    (req_accept),
      .raddr (rd_addr),
      .rdata (right_q)
   );

   // never-written entries read as zero
   assign left_dly  = valid_ff ? $signed(left_q)  : '0;
   assign right_dly = valid_ff ? $signed(right_q) : '0;

   // ---- echo datapath ----
   always_comb begin
      ctl.load_in = req_accept;
      ctl.mul1    = (state_ff == ST_MUL1);
      ctl.mix     = (state_ff == ST_MIX);
      ctl.mul2    = (state_ff == ST_MUL2);
      ctl.sum     = (state_ff == ST_SUM);
      ctl.stereo  = stereo_ff;
   end

   fdl_mix u_mix (
      .clock       (clock),
      .ctl         (ctl),
      .left_in     (left_in),
      .right_in    (right_in),
      .left_dly    (left_dly),
      .right_dly   (right_dly),
      .decay       (decay_ff),
      .wet         (wet_eff),
      .dry         (dry_eff),
      .left_out    (left_res),
      .right_out   (right_res),
      .left_wdata  (left_wdata),
      .right_wdata (right_wdata)
   );

   // ---- assertions ----
   // the tap never lands on the entry this item will write
   a_tap_not_write: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (rd_addr != w_ff))
      else $error("delay tap hits write entry");

   // write index stays inside the store
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      w_ff <= LAST_ADDR)
      else $error("write index out of range");

   // a new result only appears from the write-back step
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !$past(rsp_tvalid_ff && !rsp_tready)) |->
         $past(state_ff == ST_WRITE))
      else $error("result without write-back");

   // memory write and item accept never share a cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !req_accept)
      else $error("write-back overlaps accept");

endmodule

`default_nettype wire
